// ----- rtl/asdh_pkg.sv -----
// Shared types and constants for the second-derivative sharpness histogram.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package asdh_pkg;
  localparam int MAX_WIDTH = 2048;
  localparam int MAX_STEP  = 4;
  localparam int BINS      = 256;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WID_W     = $clog2(MAX_WIDTH + 1);
  localparam int STEP_W    = $clog2(MAX_STEP + 1);
  localparam int RING_W    = $clog2(2 * MAX_STEP);
  localparam int WIN_DEPTH = 2 * MAX_STEP;
  localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
  localparam int BIN_W     = $clog2(BINS);
  localparam int LADDR_W   = RING_W + COL_W;

  localparam int PIX_W     = 8;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_STEP   = 2'd2,
    REG_MARGIN = 2'd3
  } reg_idx_t;

  // Request into the line buffer, built at the accept edge.
  typedef struct packed {
    cmd_t              cmd;
    logic [PIX_W-1:0]  pix;
    logic [BIN_W-1:0]  sel;
    logic              eval;
    logic [COL_W-1:0]  col;
    logic [RING_W-1:0] row;
    logic [STEP_W-1:0] step;
    logic [WID_W-1:0]  width;
  } push_req_t;

  // Histogram operation handed to the bin store.
  typedef struct packed {
    logic             vld;
    cmd_t             cmd;
    logic [BIN_W-1:0] bin;
  } bin_op_t;

  // Read response leaving the bin store.
  typedef struct packed {
    logic             vld;
    logic [BIN_W-1:0] bin;
    logic [CNT_W-1:0] count;
  } bin_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/asdh_in_if.sv -----
// Input request channel of the sharpness histogram.
// Depends on asdh_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface asdh_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic [asdh_pkg::PIX_W-1:0]    pixel;
  logic [asdh_pkg::BIN_W-1:0]    bin_select;
  modport source (output valid, command, pixel, bin_select, input ready);
  modport sink (input valid, command, pixel, bin_select, output ready);
endinterface
`default_nettype wire

// ----- rtl/asdh_out_if.sv -----
// Result channel of the sharpness histogram: one bin per read request.
// Depends on asdh_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface asdh_out_if;
  logic                          valid;
  logic                          ready;
  logic [asdh_pkg::BIN_W-1:0]    bin_index;
  logic [asdh_pkg::CNT_W-1:0]    bin_count;
  modport source (output valid, bin_index, bin_count, input ready);
  modport sink (input valid, bin_index, bin_count, output ready);
endinterface
`default_nettype wire

// ----- rtl/asdh_cfg_if.sv -----
// Register write channel of the sharpness histogram.
// Depends on asdh_pkg for index and data widths.
`timescale 1ns / 1ps
`default_nettype none
interface asdh_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [asdh_pkg::CFG_IDX_W-1:0]  index;
  logic [asdh_pkg::CFG_DAT_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/abs_second_derivative_histogram.sv -----
// Second-derivative sharpness histogram. Takes one request per clock while ready
// is high: a pixel push, a bin read or a histogram clear. Each push is written to
// a 16K x 8 line store (two read ports, one write port) and, when its centre lies
// inside the margins, bumps one of 256 32-bit bins held in a single-port-write
// memory with forwarding. A read's result passes the line-buffer stage, the
// bin-operation register and the bin-store stage into the output register behind
// out_rsp.valid; input ready drops only when that register is full, not taken, and
// another read reaches the bin stage. The histogram is zero after reset and after
// a clear. Any register write restarts the raster at row 0, column 0.
`timescale 1ns / 1ps
`default_nettype none
module abs_second_derivative_histogram (
  input logic       clk,
  input logic       rst_n,
  asdh_in_if.sink   in_req,
  asdh_out_if.source out_rsp,
  asdh_cfg_if.sink  cfg_wr
);
  logic [11:0] width_r;
  logic [15:0] height_r;
  logic [2:0]  step_r;
  logic [9:0]  margin_r;

  logic [asdh_pkg::WID_W-1:0]  w_eff;
  logic [15:0]                 h_eff;
  logic [asdh_pkg::STEP_W-1:0] s_eff;
  logic [9:0]                  m_eff;
  logic                        size_ok, eval;
  logic [16:0]                 row_lo, row_sum, row_hi;
  logic [asdh_pkg::WID_W:0]    col_sum;

  logic [asdh_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [15:0]                 row_r, row_nxt;
  logic [asdh_pkg::WID_W-1:0]  col_inc;
  logic [16:0]                 row_inc;

  logic adv, acc, cfg_acc;
  asdh_pkg::push_req_t req;
  asdh_pkg::bin_op_t   op;
  asdh_pkg::bin_rsp_t  rsp;

  logic                       out_vld_r;
  logic [asdh_pkg::BIN_W-1:0] out_bin_r;
  logic [asdh_pkg::CNT_W-1:0] out_cnt_r;

  assign cfg_wr.ready = 1'b1;
  assign cfg_acc      = cfg_wr.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd640;
      height_r <= 16'd480;
      step_r   <= 3'd1;
      margin_r <= 10'd1;
    end else if (cfg_acc) begin
      unique case (asdh_pkg::reg_idx_t'(cfg_wr.index))
        asdh_pkg::REG_WIDTH:  width_r  <= cfg_wr.data[11:0];
        asdh_pkg::REG_HEIGHT: height_r <= cfg_wr.data[15:0];
        asdh_pkg::REG_STEP:   step_r   <= cfg_wr.data[2:0];
        asdh_pkg::REG_MARGIN: margin_r <= cfg_wr.data[9:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers to usable values.
  always_comb begin
    if (width_r == '0) begin
      w_eff = asdh_pkg::WID_W'(1);
    end else if (width_r > 12'(asdh_pkg::MAX_WIDTH)) begin
      w_eff = asdh_pkg::WID_W'(asdh_pkg::MAX_WIDTH);
    end else begin
      w_eff = asdh_pkg::WID_W'(width_r);
    end
    h_eff = (height_r == '0) ? 16'd1 : height_r;
    if (step_r == '0) begin
      s_eff = asdh_pkg::STEP_W'(1);
    end else if (step_r > 3'(asdh_pkg::MAX_STEP)) begin
      s_eff = asdh_pkg::STEP_W'(asdh_pkg::MAX_STEP);
    end else begin
      s_eff = asdh_pkg::STEP_W'(step_r);
    end
    m_eff   = (margin_r > 10'(s_eff)) ? margin_r : 10'(s_eff);
    size_ok = (17'(w_eff) > 17'({m_eff, 1'b0})) && (17'(h_eff) > 17'({m_eff, 1'b0}));
    row_lo  = 17'(s_eff) + 17'(m_eff);
    row_sum = 17'(row_r) + 17'(m_eff);
    row_hi  = 17'(h_eff) - 17'd1 + 17'(s_eff);
    col_sum = (asdh_pkg::WID_W + 1)'(col_r) + (asdh_pkg::WID_W + 1)'(m_eff);
    eval    = size_ok && (17'(row_r) >= row_lo) && (row_sum <= row_hi)
              && ((asdh_pkg::WID_W + 1)'(col_r) >= (asdh_pkg::WID_W + 1)'(m_eff))
              && (col_sum <= (asdh_pkg::WID_W + 1)'(w_eff) - 1'b1);
  end

  assign adv          = !(rsp.vld && out_vld_r && !out_rsp.ready);
  assign in_req.ready = adv;
  assign acc          = in_req.valid && adv;

  always_comb begin
    col_inc = asdh_pkg::WID_W'(col_r) + 1'b1;
    row_inc = 17'(row_r) + 17'd1;
    col_nxt = col_r;
    row_nxt = row_r;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= 17'(h_eff)) ? '0 : row_inc[15:0];
    end else begin
      col_nxt = col_inc[asdh_pkg::COL_W-1:0];
    end
  end

  // Raster position of the next pixel.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_acc) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc && asdh_pkg::cmd_t'(in_req.command) == asdh_pkg::CMD_PUSH) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_comb begin
    req.cmd   = asdh_pkg::cmd_t'(in_req.command);
    req.pix   = in_req.pixel;
    req.sel   = in_req.bin_select;
    req.eval  = eval;
    req.col   = col_r;
    req.row   = row_r[asdh_pkg::RING_W-1:0];
    req.step  = s_eff;
    req.width = w_eff;
  end

  asdh_line_buf u_line_buf (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .acc   (acc),
    .req   (req),
    .op    (op)
  );

  asdh_bin_store u_bin_store (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .op    (op),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && rsp.vld) begin
      out_vld_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && rsp.vld) begin
      out_bin_r <= rsp.bin;
      out_cnt_r <= rsp.count;
    end
  end

  assign out_rsp.valid     = out_vld_r;
  assign out_rsp.bin_index = out_bin_r;
  assign out_rsp.bin_count = out_cnt_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_req.ready |-> (out_rsp.valid && !out_rsp.ready))
    else $error("input stalled without a blocked result");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    (asdh_pkg::WID_W'(col_r) < w_eff) || $past(cfg_acc))
    else $error("column position beyond frame width");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r < h_eff) || $past(cfg_acc))
    else $error("row position beyond frame height");
endmodule
`default_nettype wire

// ----- rtl/asdh_line_buf.sv -----
// Line store memory, column window and second-derivative evaluation.
// Depends on asdh_pkg; feeds bin operations to asdh_bin_store.
`timescale 1ns / 1ps
`default_nettype none
module asdh_line_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                acc,
  input  asdh_pkg::push_req_t req,
  output asdh_pkg::bin_op_t   op
);
  logic [asdh_pkg::PIX_W-1:0] mem [2**asdh_pkg::LADDR_W];

  logic [asdh_pkg::PIX_W-1:0]  rda_r, rdb_r;
  logic [asdh_pkg::WID_W-1:0]  sum_a;
  logic                        wrap_a;
  logic [asdh_pkg::COL_W-1:0]  col_a;
  logic [asdh_pkg::RING_W-1:0] row_a, row_b, step_ring;
  logic [asdh_pkg::LADDR_W-1:0] addr_a, addr_b, addr_w;

  logic                        s1_vld_r;
  asdh_pkg::cmd_t              s1_cmd_r;
  logic [asdh_pkg::PIX_W-1:0]  s1_pix_r;
  logic [asdh_pkg::BIN_W-1:0]  s1_sel_r;
  logic                        s1_eval_r;
  logic [asdh_pkg::STEP_W-1:0] s1_step_r;

  logic [asdh_pkg::PIX_W-1:0]  win_r [asdh_pkg::WIN_DEPTH];
  logic [asdh_pkg::WIN_IDX_W-1:0] idx_ctr, idx_left;
  logic [asdh_pkg::PIX_W-1:0]  ctr, left;
  logic [asdh_pkg::PIX_W:0]    sum_x, sum_y;
  logic [asdh_pkg::PIX_W-1:0]  avg_x, avg_y, dx, dy, dmax;

  logic                        op_vld_r;
  asdh_pkg::cmd_t              op_cmd_r;
  logic [asdh_pkg::BIN_W-1:0]  op_bin_r;

  // Right tap runs s pixels ahead in raster order, wrapping into the next row.
  always_comb begin
    step_ring = asdh_pkg::RING_W'(req.step);
    sum_a     = asdh_pkg::WID_W'(req.col) + asdh_pkg::WID_W'(req.step);
    wrap_a    = (sum_a >= req.width);
    col_a     = wrap_a ? asdh_pkg::COL_W'(sum_a - req.width) : asdh_pkg::COL_W'(sum_a);
    row_a     = req.row - step_ring + asdh_pkg::RING_W'(wrap_a);
    row_b     = req.row - asdh_pkg::RING_W'({step_ring, 1'b0});
    addr_a    = {row_a, col_a};
    addr_b    = {row_b, req.col};
    addr_w    = {req.row, req.col};
  end

  // Reads see the old entry when the write hits the same slot.
  always_ff @(posedge clk) begin
    if (adv) begin
      rda_r <= mem[addr_a];
      rdb_r <= mem[addr_b];
    end
    if (acc && req.cmd == asdh_pkg::CMD_PUSH) begin
      mem[addr_w] <= req.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r  <= req.cmd;
      s1_pix_r  <= req.pix;
      s1_sel_r  <= req.sel;
      s1_eval_r <= req.eval;
      s1_step_r <= req.step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < asdh_pkg::WIN_DEPTH; i++) begin
        win_r[i] <= '0;
      end
    end else if (adv && s1_vld_r && s1_cmd_r == asdh_pkg::CMD_PUSH) begin
      win_r[0] <= rda_r;
      for (int i = 1; i < asdh_pkg::WIN_DEPTH; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  always_comb begin
    idx_ctr  = asdh_pkg::WIN_IDX_W'(s1_step_r - 1'b1);
    idx_left = asdh_pkg::WIN_IDX_W'({s1_step_r, 1'b0} - 1'b1);
    ctr      = win_r[idx_ctr];
    left     = win_r[idx_left];
    sum_x    = {1'b0, left} + {1'b0, rda_r} + 1'b1;
    sum_y    = {1'b0, rdb_r} + {1'b0, s1_pix_r} + 1'b1;
    avg_x    = sum_x[asdh_pkg::PIX_W:1];
    avg_y    = sum_y[asdh_pkg::PIX_W:1];
    dx       = (avg_x > ctr) ? avg_x - ctr : ctr - avg_x;
    dy       = (avg_y > ctr) ? avg_y - ctr : ctr - avg_y;
    dmax     = (dx > dy) ? dx : dy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_vld_r <= 1'b0;
    end else if (adv) begin
      op_vld_r <= s1_vld_r && (s1_cmd_r == asdh_pkg::CMD_READ
                  || s1_cmd_r == asdh_pkg::CMD_CLEAR
                  || (s1_cmd_r == asdh_pkg::CMD_PUSH && s1_eval_r));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op_cmd_r <= s1_cmd_r;
      op_bin_r <= (s1_cmd_r == asdh_pkg::CMD_PUSH) ? asdh_pkg::BIN_W'(dmax) : s1_sel_r;
    end
  end

  always_comb begin
    op.vld = op_vld_r;
    op.cmd = op_cmd_r;
    op.bin = op_bin_r;
  end
endmodule
`default_nettype wire

// ----- rtl/asdh_bin_store.sv -----
// Histogram memory with read-modify-write increment, clear and bin read.
// Depends on asdh_pkg; takes operations from asdh_line_buf.
`timescale 1ns / 1ps
`default_nettype none
module asdh_bin_store (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  asdh_pkg::bin_op_t  op,
  output asdh_pkg::bin_rsp_t rsp
);
  logic [asdh_pkg::CNT_W-1:0] mem [asdh_pkg::BINS];
  logic [asdh_pkg::BINS-1:0]  bin_vld_r;

  logic                       s3_vld_r;
  asdh_pkg::cmd_t             s3_cmd_r;
  logic [asdh_pkg::BIN_W-1:0] s3_bin_r;
  logic [asdh_pkg::CNT_W-1:0] rdata_r, fwd_val_r, cur, inc_val;
  logic                       vbit_r, fwd_sel_r;
  logic                       do_inc, do_clr, hit;

  always_comb begin
    cur     = fwd_sel_r ? fwd_val_r : (vbit_r ? rdata_r : '0);
    inc_val = cur + 1'b1;
    do_inc  = adv && s3_vld_r && s3_cmd_r == asdh_pkg::CMD_PUSH;
    do_clr  = adv && s3_vld_r && s3_cmd_r == asdh_pkg::CMD_CLEAR;
    hit     = s3_vld_r && s3_cmd_r == asdh_pkg::CMD_PUSH && s3_bin_r == op.bin;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rdata_r <= mem[op.bin];
    end
    if (do_inc) begin
      mem[s3_bin_r] <= inc_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_vld_r <= '0;
    end else if (do_clr) begin
      bin_vld_r <= '0;
    end else if (do_inc) begin
      bin_vld_r[s3_bin_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= op.vld;
    end
  end

  // Forward the write or clear that lands on the same edge as this read.
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_cmd_r  <= op.cmd;
      s3_bin_r  <= op.bin;
      vbit_r    <= bin_vld_r[op.bin];
      fwd_sel_r <= hit || (s3_vld_r && s3_cmd_r == asdh_pkg::CMD_CLEAR);
      fwd_val_r <= (s3_cmd_r == asdh_pkg::CMD_CLEAR) ? '0 : inc_val;
    end
  end

  always_comb begin
    rsp.vld   = s3_vld_r && s3_cmd_r == asdh_pkg::CMD_READ;
    rsp.bin   = s3_bin_r;
    rsp.count = cur;
  end
endmodule
`default_nettype wire
